>>> design/b128m_pkg.sv
package b128m_pkg;

  localparam int EXP_W            = 15;
  localparam logic [EXP_W-1:0] EXP_MAX = 15'h7FFF;
  localparam int BIAS             = 'h3FFF;
  localparam int FRAC_HI_BITS     = 48;
  localparam int FRAC_W           = 64 + FRAC_HI_BITS;
  localparam int MANT_W           = FRAC_W + 1;
  localparam int PROD_W           = 2 * MANT_W;
  localparam int MAX_DENORM_SHIFT = 114;
  localparam int HALF_POS         = 47;
  localparam int GUARD_POS        = 64 + HALF_POS;
  localparam int EXT_W            = 18;

  localparam int LIMB_W = 29;
  localparam int LIMBS  = 4;
  localparam int PAD_W  = LIMB_W * LIMBS;
  localparam int COLS   = 2 * LIMBS - 1;
  localparam int COL_W  = 2 * LIMB_W + 2;

  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [EXT_W-1:0]  exp_ext_t;

  typedef struct packed {
    logic pp;
    logic col;
    logic half;
    logic sum;
  } mul_en_t;

  typedef struct packed {
    logic         sgn;
    logic         spec;
    logic [127:0] spec_val;
  } side_t;

  typedef struct packed {
    logic             sgn;
    logic             spec;
    logic [127:0]     spec_val;
    logic             ovf;
    logic             zero_uf;
    logic [EXP_W-1:0] exp_add;
  } rnd_t;

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd15;
    for (int k = 0; k < 16; k++) begin
      if (v[k]) begin
        n = 4'(15 - k);
      end
    end
    return n;
  endfunction

endpackage

>>> design/b128m_mant_mul.sv
module b128m_mant_mul (
  input  logic                clk,
  input  b128m_pkg::mul_en_t  en,
  input  b128m_pkg::mant_t    a,
  input  b128m_pkg::mant_t    b,
  output b128m_pkg::prod_t    prod
);

  localparam int LW    = b128m_pkg::LIMB_W;
  localparam int NL    = b128m_pkg::LIMBS;
  localparam int NC    = b128m_pkg::COLS;
  localparam int CW    = b128m_pkg::COL_W;
  localparam int PW    = b128m_pkg::PROD_W;
  localparam int PADW  = b128m_pkg::PAD_W;

  logic [PADW-1:0] a_pad;
  logic [PADW-1:0] b_pad;
  logic [2*LW-1:0] pp_r [NL][NL];
  logic [CW-1:0]   col_nxt [NC];
  logic [CW-1:0]   col_r [NC];
  logic [PW-1:0]   even_nxt;
  logic [PW-1:0]   odd_nxt;
  logic [PW-1:0]   even_r;
  logic [PW-1:0]   odd_r;
  logic [PW-1:0]   prod_r;

  assign a_pad = PADW'(a);
  assign b_pad = PADW'(b);

  // limb products
  always_ff @(posedge clk) begin
    if (en.pp) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_r[i][j] <= (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
        end
      end
    end
  end

  // column sums of equal weight
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      col_nxt[k] = '0;
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          if (i + j == k) begin
            col_nxt[k] = col_nxt[k] + CW'(pp_r[i][j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.col) begin
      col_r <= col_nxt;
    end
  end

  always_comb begin
    even_nxt = '0;
    odd_nxt  = '0;
    for (int k = 0; k < NC; k++) begin
      if (k % 2 == 0) begin
        even_nxt = even_nxt + (PW'(col_r[k]) << (k * LW));
      end else begin
        odd_nxt = odd_nxt + (PW'(col_r[k]) << (k * LW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.half) begin
      even_r <= even_nxt;
      odd_r  <= odd_nxt;
    end
    if (en.sum) begin
      prod_r <= even_r + odd_r;
    end
  end

  assign prod = prod_r;

endmodule

>>> design/binary128_float_multiply.sv
// IEEE binary128 multiplier, round to nearest even, no flags. Fully pipelined: one
// request accepted per cycle while in_stall is low. Stages: unpack and chunk leading-zero
// count, coarse and fine normalise of a subnormal operand, four stages of 29-bit limb
// multiply and summation, coarse and fine alignment with sticky, then round and pack into
// the output register. Each stage holds its request while the next is full and cannot
// advance, so a stalled output fills the pipeline before in_stall rises. NaN operands pass
// through unchanged (x first), infinity times zero returns the infinity with bit 0 of the
// high half set, and products below the subnormal range flush to signed zero.
module binary128_float_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_x_high,
  input  logic [63:0] in_x_low,
  input  logic [63:0] in_y_high,
  input  logic [63:0] in_y_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_product_high,
  output logic [63:0] out_product_low
);

  localparam int STAGES = 10;
  localparam int MW     = b128m_pkg::MANT_W;
  localparam int PW     = b128m_pkg::PROD_W;
  localparam int FW     = b128m_pkg::FRAC_W;
  localparam int EW     = b128m_pkg::EXP_W;
  localparam int XW     = b128m_pkg::EXT_W;
  localparam int GP     = b128m_pkg::GUARD_POS;
  localparam int LOW_W  = GP + 16;

  // handshake and stage enables
  logic [STAGES:1] v_r;
  logic [STAGES:1] v_in;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !v_r[STAGES] || !out_stall;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign v_in     = {v_r[STAGES-1:1], in_valid};
  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // stage 1: unpack, classify, chunk leading zeros
  logic [EW-1:0]     x_exp, y_exp, n_exp, d_exp;
  logic [FW-1:0]     x_frac, y_frac, n_frac, d_frac;
  logic              x_fnz, y_fnz, x_ez, y_ez;
  logic              x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
  logic              sgn1, swap1, d_sub1;
  logic [127:0]      u1;
  b128m_pkg::side_t  side1_nxt;
  b128m_pkg::mant_t  m1_nxt, mn1_nxt;
  logic [EW+1:0]     esum1_nxt;
  logic [7:0]        nz1_nxt;
  logic [3:0]        lz1_nxt [8];

  assign x_exp  = in_x_high[62:48];
  assign y_exp  = in_y_high[62:48];
  assign x_frac = {in_x_high[47:0], in_x_low};
  assign y_frac = {in_y_high[47:0], in_y_low};
  assign x_fnz  = |x_frac;
  assign y_fnz  = |y_frac;
  assign x_ez   = (x_exp == '0);
  assign y_ez   = (y_exp == '0);
  assign x_nan  = (x_exp == b128m_pkg::EXP_MAX) && x_fnz;
  assign y_nan  = (y_exp == b128m_pkg::EXP_MAX) && y_fnz;
  assign x_inf  = (x_exp == b128m_pkg::EXP_MAX) && !x_fnz;
  assign y_inf  = (y_exp == b128m_pkg::EXP_MAX) && !y_fnz;
  assign x_zero = x_ez && !x_fnz;
  assign y_zero = y_ez && !y_fnz;
  assign sgn1   = in_x_high[63] ^ in_y_high[63];

  always_comb begin
    side1_nxt.sgn      = sgn1;
    side1_nxt.spec     = 1'b1;
    side1_nxt.spec_val = '0;
    priority if (x_nan) begin
      side1_nxt.spec_val = {in_x_high, in_x_low};
    end else if (y_nan) begin
      side1_nxt.spec_val = {in_y_high, in_y_low};
    end else if (x_inf && y_zero) begin
      side1_nxt.spec_val = {in_x_high | 64'd1, in_x_low};
    end else if (y_inf && x_zero) begin
      side1_nxt.spec_val = {in_y_high | 64'd1, in_y_low};
    end else if (x_inf || y_inf) begin
      side1_nxt.spec_val = {sgn1, b128m_pkg::EXP_MAX, 112'b0};
    end else if ((x_ez && y_ez) || x_zero || y_zero) begin
      side1_nxt.spec_val = {sgn1, 127'b0};
    end else begin
      side1_nxt.spec = 1'b0;
    end
  end

  // a subnormal x takes the normalising side
  assign swap1  = x_ez;
  assign n_exp  = swap1 ? y_exp : x_exp;
  assign n_frac = swap1 ? y_frac : x_frac;
  assign d_exp  = swap1 ? x_exp : y_exp;
  assign d_frac = swap1 ? x_frac : y_frac;
  assign d_sub1 = (d_exp == '0);

  assign m1_nxt    = {!d_sub1, d_frac};
  assign mn1_nxt   = {1'b1, n_frac};
  assign esum1_nxt = (EW+2)'(n_exp) + (EW+2)'(d_exp) + (EW+2)'(d_sub1);
  assign u1        = {m1_nxt, 15'b0};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nz1_nxt[i] = |u1[127-16*i -: 16];
      lz1_nxt[i] = b128m_pkg::lzc16(u1[127-16*i -: 16]);
    end
  end

  b128m_pkg::side_t side_r [1:7];
  b128m_pkg::mant_t m1_r, mn1_r, m2_r, mn2_r, m3_r, mn3_r;
  logic [EW+1:0]    esum1_r, esum2_r;
  logic [7:0]       nz1_r;
  logic [3:0]       lz1_r [8];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1] <= side1_nxt;
      m1_r      <= m1_nxt;
      mn1_r     <= mn1_nxt;
      esum1_r   <= esum1_nxt;
      nz1_r     <= nz1_nxt;
      lz1_r     <= lz1_nxt;
    end
  end

  // stage 2: coarse normalise by whole chunks
  logic [2:0]       c2_nxt, c2_r;
  b128m_pkg::mant_t m2_nxt;
  logic [3:0]       fine2_nxt, fine2_r;

  always_comb begin
    c2_nxt = '0;
    for (int i = 7; i >= 0; i--) begin
      if (nz1_r[i]) begin
        c2_nxt = 3'(i);
      end
    end
  end

  assign m2_nxt    = m1_r << {c2_nxt, 4'b0};
  assign fine2_nxt = lz1_r[c2_nxt];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_r[2] <= side_r[1];
      m2_r      <= m2_nxt;
      mn2_r     <= mn1_r;
      esum2_r   <= esum1_r;
      c2_r      <= c2_nxt;
      fine2_r   <= fine2_nxt;
    end
  end

  // stage 3: fine normalise, unbiased exponent sum
  b128m_pkg::mant_t      m3_nxt;
  logic [6:0]            s3;
  b128m_pkg::exp_ext_t   e0_3_nxt;
  b128m_pkg::exp_ext_t   e0_r [3:7];

  assign m3_nxt   = m2_r << fine2_r;
  assign s3       = {c2_r, fine2_r};
  assign e0_3_nxt = {1'b0, esum2_r} - XW'(s3) - XW'(b128m_pkg::BIAS + 1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      side_r[3] <= side_r[2];
      m3_r      <= m3_nxt;
      mn3_r     <= mn2_r;
      e0_r[3]   <= e0_3_nxt;
    end
  end

  // stages 4 to 7: mantissa product
  b128m_pkg::mul_en_t mul_en;
  b128m_pkg::prod_t   prod7;

  assign mul_en.pp   = en[4];
  assign mul_en.col  = en[5];
  assign mul_en.half = en[6];
  assign mul_en.sum  = en[7];

  b128m_mant_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mn3_r),
    .b    (m3_r),
    .prod (prod7)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      side_r[4] <= side_r[3];
      e0_r[4]   <= e0_r[3];
    end
    if (en[5]) begin
      side_r[5] <= side_r[4];
      e0_r[5]   <= e0_r[4];
    end
    if (en[6]) begin
      side_r[6] <= side_r[5];
      e0_r[6]   <= e0_r[5];
    end
    if (en[7]) begin
      side_r[7] <= side_r[6];
      e0_r[7]   <= e0_r[6];
    end
  end

  // stage 8: range checks, coarse right alignment
  logic                top8, uf8, ovf8, zero8, sticky8_nxt, sticky8_r;
  b128m_pkg::exp_ext_t ex8, neg8;
  logic [6:0]          d8;
  logic [6:0]          co8;
  b128m_pkg::prod_t    q8_nxt, q8_r;
  logic [3:0]          fine8_r;
  b128m_pkg::rnd_t     rnd8_nxt, rnd8_r, rnd9_r;

  assign top8  = prod7[PW-1];
  assign ex8   = e0_r[7] + XW'(top8);
  assign uf8   = ex8[XW-1];
  assign neg8  = XW'(0) - e0_r[7];
  assign ovf8  = !uf8 && (ex8 >= XW'(b128m_pkg::EXP_MAX - 15'd1));
  assign zero8 = uf8 && (neg8 > XW'(b128m_pkg::MAX_DENORM_SHIFT));
  assign d8    = uf8 ? neg8[6:0] : 7'(top8);

  always_comb begin
    sticky8_nxt = 1'b0;
    for (int i = 0; i < 7; i++) begin
      co8[i] = |prod7[16*i +: 16];
      if (3'(i) < d8[6:4]) begin
        sticky8_nxt = sticky8_nxt | co8[i];
      end
    end
  end

  assign q8_nxt = prod7 >> {d8[6:4], 4'b0};

  always_comb begin
    rnd8_nxt.sgn      = side_r[7].sgn;
    rnd8_nxt.spec     = side_r[7].spec;
    rnd8_nxt.spec_val = side_r[7].spec_val;
    rnd8_nxt.ovf      = ovf8;
    rnd8_nxt.zero_uf  = zero8;
    rnd8_nxt.exp_add  = uf8 ? '0 : ex8[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      rnd8_r    <= rnd8_nxt;
      q8_r      <= q8_nxt;
      fine8_r   <= d8[3:0];
      sticky8_r <= sticky8_nxt;
    end
  end

  // stage 9: fine alignment, guard and sticky
  b128m_pkg::prod_t s9;
  logic [6:0]       sh9;
  logic [LOW_W-1:0] lowmask9;
  b128m_pkg::mant_t mant9_r;
  logic             g9_r, sticky9_r;

  assign s9       = q8_r >> fine8_r;
  assign sh9      = 7'(GP) + 7'(fine8_r);
  assign lowmask9 = ~({LOW_W{1'b1}} << sh9);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      rnd9_r    <= rnd8_r;
      mant9_r   <= s9[PW-2 -: MW];
      g9_r      <= s9[GP];
      sticky9_r <= sticky8_r | (|(q8_r[LOW_W-1:0] & lowmask9));
    end
  end

  // stage 10: round and pack
  logic         inc10;
  logic [127:0] rounded10, res10;
  logic [63:0]  out_hi_r, out_lo_r;

  assign inc10     = g9_r && (sticky9_r || mant9_r[0]);
  assign rounded10 = 128'(mant9_r) + 128'(inc10) + {1'b0, rnd9_r.exp_add, 112'b0};

  always_comb begin
    priority if (rnd9_r.spec) begin
      res10 = rnd9_r.spec_val;
    end else if (rnd9_r.ovf) begin
      res10 = {rnd9_r.sgn, b128m_pkg::EXP_MAX, 112'b0};
    end else if (rnd9_r.zero_uf) begin
      res10 = {rnd9_r.sgn, 127'b0};
    end else begin
      res10 = rounded10 | {rnd9_r.sgn, 127'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      out_hi_r <= res10[127:64];
      out_lo_r <= res10[63:0];
    end
  end

  assign out_valid        = v_r[STAGES];
  assign out_product_high = out_hi_r;
  assign out_product_low  = out_lo_r;

  a_empty_entry_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[1] |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_norm_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !side_r[3].spec) |-> m3_r[MW-1])
    else $error("normalised mantissa lacks leading one");

  a_prod_top_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[7] && !side_r[7].spec) |-> (prod7[PW-1] || prod7[PW-2]))
    else $error("product of normalised mantissas too small");

  a_range_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[9] |-> !(rnd9_r.ovf && rnd9_r.zero_uf))
    else $error("overflow and underflow flagged together");

  a_stalled_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[9] && !en[10]) |=> v_r[9])
    else $error("stalled request dropped from alignment stage");

endmodule

>>> tb/tb_top.sv
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_x_high;
  logic [63:0] in_x_low;
  logic [63:0] in_y_high;
  logic [63:0] in_y_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_product_high;
  logic [63:0] out_product_low;

  localparam logic [63:0] NEG_MASK   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] HIDDEN_BIT = 64'h0001_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK  = 64'h0000_FFFF_FFFF_FFFF;
  localparam int          BIAS_VAL   = 'h3FFF;
  localparam int          EXP_TOP    = 'h7FFF;
  localparam int          N_RANDOM   = 1050;

  typedef struct {
    logic [63:0] xh, xl, yh, yl;
    logic        typed;
    logic [63:0] ph, pl;
  } mul_row_t;

  mul_row_t      directed[$];
  logic [127:0]  product_q[$];
  int            n_errors;
  int            n_products;
  int            n_special;

  binary128_float_multiply u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_high        (in_x_high),
    .in_x_low         (in_x_low),
    .in_y_high        (in_y_high),
    .in_y_low         (in_y_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_product_high (out_product_high),
    .out_product_low  (out_product_low)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [127:0] quad_product(logic [63:0] ah, logic [63:0] al,
                                                logic [63:0] bh, logic [63:0] bl);
    int           ea, eb, ex, n, shv, sh, ls;
    logic [63:0]  t, sgn, top, inc, hi, lo, w0, w1, w2, w3;
    logic [255:0] acc;
    logic [191:0] upper;
    ea = int'(ah[62:48]);
    eb = int'(bh[62:48]);
    if (ea == EXP_TOP) begin
      t = ah; ah = bh; bh = t;
      t = al; al = bl; bl = t;
      ea = eb; eb = EXP_TOP;
    end
    if (eb == EXP_TOP) begin
      if (((bh << 16) | bl) != 0) return {bh, bl};
      if (ea == EXP_TOP && ((ah << 16) | al) != 0) return {ah, al};
      if (((ah << 1) | al) == 0) return {bh | 64'd1, bl};
      ea = eb;
    end
    if (ea == 0) begin
      t = ah; ah = bh; bh = t;
      t = al; al = bl; bl = t;
      ea = eb; eb = 0;
    end
    if (eb == 0) begin
      n = 0;
      sgn = bh & NEG_MASK;
      bh[63] = 1'b0;
      if (bh == 0) begin
        if (bl == 0) begin
          bl = '1;
          eb = -(1 << 17);
        end
        do begin
          bh = bl >> 16;
          bl = bl << 48;
          ea -= 48;
        end while (bh == 0);
      end
      while (bh[48] == 1'b0) begin
        bh = {bh[62:0], bl[63]};
        bl = bl << 1;
        n++;
      end
      eb = eb + 1 - n;
      bh |= sgn;
    end
    ex = ea + eb - BIAS_VAL - 1;
    sgn = (ah ^ bh) & NEG_MASK;
    ah = (ah & FRAC_MASK) | HIDDEN_BIT;
    bh = (bh & FRAC_MASK) | HIDDEN_BIT;
    acc = 256'(128'(al) * 128'(bl));
    acc += 256'(128'(ah) * 128'(bl)) << 64;
    acc += 256'(128'(al) * 128'(bh)) << 64;
    acc += 256'(128'(ah) * 128'(bh)) << 128;
    {w3, w2, w1, w0} = acc;
    top = 64'(w3[33]);
    ex += int'(top);
    if (ex >= EXP_TOP - 1) begin
      w3 = 0; w2 = 0; w1 = 0;
      ex = EXP_TOP;
    end
    if (ex < 0) begin
      shv = int'(top) - ex;
      if (shv > 114) return {sgn, 64'd0};
      sh = shv;
      if (sh >= 64) begin
        w0 |= w1;
        w1 = w2;
        w2 = w3;
        w3 = 0;
        sh -= 64;
      end
      if (sh > 0) begin
        w0 = w0 | (w1 << (64 - sh));
        w1 = (w1 >> sh) | (w2 << (64 - sh));
        w2 = (w2 >> sh) | (w3 << (64 - sh));
        w3 = w3 >> sh;
      end
      ex = 0;
      top = 0;
    end
    inc = (top + 64'd1) << 47;
    upper = {w3, w2, w1} + 192'(inc);
    {w3, w2, w1} = upper;
    ls = 16 - int'(top);
    hi = (w3 << ls) | (w2 >> (64 - ls));
    lo = (w2 << ls) | (w1 >> (64 - ls));
    hi += 64'(unsigned'(ex)) << 48;
    hi |= sgn;
    if ((w1 & (inc * 2 - 64'd1)) == 0 && w0 == 0) lo[0] = 1'b0;
    return {hi, lo};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_fraction();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  function automatic int rand_exp(int partner);
    int e;
    case ($urandom_range(0, 9))
      0: e = 0;
      1: e = EXP_TOP;
      2: e = EXP_TOP - 1;
      3: e = 1;
      4: e = 2 * BIAS_VAL + 1 - partner + $urandom_range(0, 6) - 3;
      5: e = BIAS_VAL - partner + $urandom_range(0, 240) - 120;
      6: e = BIAS_VAL + $urandom_range(0, 64) - 32;
      default: e = $urandom_range(0, EXP_TOP);
    endcase
    if (e < 0) e = $urandom_range(0, 3);
    if (e > EXP_TOP) e = EXP_TOP - $urandom_range(0, 2);
    return e;
  endfunction

  function automatic logic [63:0] make_high(int e);
    logic [63:0] f;
    f = rand_fraction();
    return {f[63], 15'(e), f[47:0]};
  endfunction

  task automatic add_row(logic [63:0] xh, logic [63:0] xl, logic [63:0] yh, logic [63:0] yl,
                         logic typed, logic [63:0] ph, logic [63:0] pl);
    mul_row_t r;
    r.xh = xh; r.xl = xl; r.yh = yh; r.yl = yl;
    r.typed = typed; r.ph = ph; r.pl = pl;
    directed.push_back(r);
  endtask

  task automatic send_request(mul_row_t r);
    in_valid  <= 1'b1;
    in_x_high <= r.xh;
    in_x_low  <= r.xl;
    in_y_high <= r.yh;
    in_y_low  <= r.yl;
    do @(posedge clk); while (in_stall);
    if (r.typed) product_q.push_back({r.ph, r.pl});
    else product_q.push_back(quad_product(r.xh, r.xl, r.yh, r.yl));
  endtask

  int burst_left;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver stall pattern, switches at random among four modes of stalling
  int stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_cnt % 16) < 9);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected product %h_%h", $time, out_product_high, out_product_low);
        n_errors++;
      end else begin
        want = product_q.pop_front();
        n_products++;
        if (out_product_high !== want[127:64]) begin
          $display("%0t: product_high expected %h actual %h", $time, want[127:64],
                   out_product_high);
          n_errors++;
        end
        if (out_product_low !== want[63:0]) begin
          $display("%0t: product_low expected %h actual %h", $time, want[63:0],
                   out_product_low);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    mul_row_t r;
    int       ex_x, ex_y, k;
    n_errors   = 0;
    n_products = 0;
    n_special  = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_cnt  = 1;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    in_x_high  = '0;
    in_x_low   = '0;
    in_y_high  = '0;
    in_y_low   = '0;

    add_row(64'h3FFF_0000_0000_0000, 0, 64'h3FFF_0000_0000_0000, 0,
            1, 64'h3FFF_0000_0000_0000, 0);
    add_row(0, 0, NEG_MASK, 0, 1, NEG_MASK, 0);
    add_row(64'h7FFF_0000_0000_0000, 0, 0, 0, 1, 64'h7FFF_0000_0000_0001, 0);
    add_row(0, 0, 64'hFFFF_0000_0000_0000, 0, 1, 64'hFFFF_0000_0000_0001, 0);
    add_row(64'h7FFF_0000_0000_0000, 0, 64'hBFFF_0000_0000_0000, 0,
            1, 64'hFFFF_0000_0000_0000, 0);
    add_row(64'h7FFF_8000_0000_0000, 64'h5, 64'h3FFF_0000_0000_0000, 0,
            1, 64'h7FFF_8000_0000_0000, 64'h5);
    add_row(64'h3FFF_0000_0000_0000, 0, 64'hFFFF_0000_0000_0000, 64'h1,
            1, 64'hFFFF_0000_0000_0000, 64'h1);
    add_row(64'h7FFF_0000_0000_00AB, 0, 64'hFFFF_4000_0000_0000, 0,
            1, 64'h7FFF_0000_0000_00AB, 0);
    add_row('1, '1, '1, '1, 1, '1, '1);
    add_row(64'h7FFE_FFFF_FFFF_FFFF, '1, 64'h7FFE_FFFF_FFFF_FFFF, '1,
            1, 64'h7FFF_0000_0000_0000, 0);
    add_row(0, 1, 0, 1, 1, 0, 0);
    add_row(NEG_MASK, 1, 0, 1, 1, NEG_MASK, 0);
    add_row(0, 0, 0, 0, 1, 0, 0);
    add_row(64'h0001_0000_0000_0000, 0, 64'h3FFE_0000_0000_0000, 0, 0, 0, 0);
    add_row(64'h0001_0000_0000_0000, 0, 64'h3F8D_0000_0000_0000, 0, 0, 0, 0);
    add_row(0, 1, 64'h7FFE_0000_0000_0000, 0, 0, 0, 0);
    add_row(64'h0000_8000_0000_0000, 0, 64'h4000_0000_0000_0000, 0, 0, 0, 0);
    add_row(64'h3FFF_FFFF_FFFF_FFFF, '1, 64'h3FFF_0000_0000_0000, 1, 0, 0, 0);
    add_row(64'h4000_0000_0000_0000, 0, 64'h7FFE_0000_0000_0000, 0, 0, 0, 0);
    add_row(64'hBFFF_5555_5555_5555, 64'h5555_5555_5555_5555,
            64'h3FFF_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i]);
      pace();
    end

    for (k = 0; k < N_RANDOM; k++) begin
      r.typed = 0; r.ph = 0; r.pl = 0;
      if ($urandom_range(0, 19) == 0) begin
        r.xh = rand64(); r.xl = rand64(); r.yh = rand64(); r.yl = rand64();
      end else begin
        ex_x = rand_exp(BIAS_VAL);
        ex_y = rand_exp(ex_x);
        r.xh = make_high(ex_x); r.xl = rand_fraction();
        r.yh = make_high(ex_y); r.yl = rand_fraction();
        if ($urandom_range(0, 1) == 0) begin
          {r.xh, r.xl, r.yh, r.yl} = {r.yh, r.yl, r.xh, r.xl};
        end
      end
      if (r.xh[62:48] == 15'h7FFF || r.yh[62:48] == 15'h7FFF ||
          r.xh[62:48] == 15'h0 || r.yh[62:48] == 15'h0) n_special++;
      send_request(r);
      pace();
    end
    in_valid <= 1'b0;

    k = 0;
    while (product_q.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (40) @(posedge clk);

    $display("checked %0d products: %0d directed, %0d random (%0d with a zero, subnormal,",
             n_products, directed.size(), N_RANDOM, n_special);
    $display("infinite or NaN operand), with bursty requests and varied output stalls");
    if (n_errors == 0 && product_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> binary128_float_multiply.f
design/b128m_pkg.sv
design/b128m_mant_mul.sv
design/binary128_float_multiply.sv
tb/tb_top.sv
